[rtl/wsd_pkg.sv]
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the websocket deframer and unmasker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

    // parser phases
    typedef enum logic [3:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT_HI,
        PH_EXT_LO,
        PH_MASK0,
        PH_MASK1,
        PH_MASK2,
        PH_MASK3,
        PH_PAYLOAD
    } phase_t;

    // result status codes
    localparam logic [2:0] ST_DATA        = 3'd0;
    localparam logic [2:0] ST_NOT_FINAL   = 3'd1;
    localparam logic [2:0] ST_UNMASKED    = 3'd2;
    localparam logic [2:0] ST_LONG_LENGTH = 3'd3;
    localparam logic [2:0] ST_SHORT_HDR   = 3'd4;
    localparam logic [2:0] ST_SHORT_FRAME = 3'd5;
    localparam logic [2:0] ST_EMPTY_MSG   = 3'd6;

    // frame opcode and length escapes
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // header sizes including mask key
    localparam logic [16:0] HDR_SHORT = 17'd6;
    localparam logic [16:0] HDR_EXT16 = 17'd8;

    // queue between parser and output stage
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // one request from the parser to the output stage
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] key;
        logic       frame_end;
        logic [2:0] status;
    } res_req_t;

endpackage

`default_nettype wire

[rtl/wsd_front.sv]
// ----------------------------------------------------------------------------
// wsd_front
// Frame header parser: tracks the frame phase, checks headers and fit, and
// issues one request per delivered binary payload byte or error.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsd_front
    import wsd_pkg::*;
#(
    parameter int BUFFER_BYTES = 1024
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [10:0] bytes_left,
    output logic             req_valid,
    output res_req_t         req
);

    phase_t      phase_reg,    phase_next;
    logic [3:0]  opcode_reg,   opcode_next;
    logic [15:0] length_reg,   length_next;
    logic [15:0] position_reg, position_next;
    logic [31:0] mask_reg,     mask_next;
    logic [10:0] start_reg,    start_next;
    logic        drop_reg,     drop_next;
    logic        discard_reg,  discard_next;

    logic [10:0] bl;
    logic [16:0] fit_need;
    logic        pay_end;
    logic [1:0]  key_sel;

    // clamp buffer tag to the buffer size
    always_comb
    begin
        if (32'(bytes_left) > BUFFER_BYTES)
            bl = 11'(BUFFER_BYTES);
        else
            bl = bytes_left;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR0;
            opcode_reg   <= '0;
            length_reg   <= '0;
            position_reg <= '0;
            mask_reg     <= '0;
            start_reg    <= '0;
            drop_reg     <= 1'b0;
            discard_reg  <= 1'b0;
        end
        else if (in_valid)
        begin
            phase_reg    <= phase_next;
            opcode_reg   <= opcode_next;
            length_reg   <= length_next;
            position_reg <= position_next;
            mask_reg     <= mask_next;
            start_reg    <= start_next;
            drop_reg     <= drop_next;
            discard_reg  <= discard_next;
        end
    end

    // next state and request
    always_comb
    begin
        phase_next    = phase_reg;
        opcode_next   = opcode_reg;
        length_next   = length_reg;
        position_next = position_reg;
        mask_next     = mask_reg;
        start_next    = start_reg;
        drop_next     = drop_reg;
        discard_next  = discard_reg;
        req_valid     = 1'b0;
        req           = '0;
        fit_need      = '0;
        pay_end       = (17'(position_reg) + 17'd1) == 17'(length_reg);
        key_sel       = position_reg[1:0];

        if (!discard_reg)
        begin
            unique case (phase_reg) inside
                PH_HDR0:
                begin
                    start_next = bl;
                    if (bl < 11'd6)
                    begin
                        req_valid    = 1'b1;
                        req.status   = ST_SHORT_HDR;
                        discard_next = 1'b1;
                    end
                    else if (!rx_byte[7])
                    begin
                        req_valid    = 1'b1;
                        req.status   = ST_NOT_FINAL;
                        discard_next = 1'b1;
                    end
                    else
                    begin
                        opcode_next = rx_byte[3:0];
                        phase_next  = PH_HDR1;
                    end
                end
                PH_HDR1:
                begin
                    if (!rx_byte[7])
                    begin
                        req_valid    = 1'b1;
                        req.status   = ST_UNMASKED;
                        discard_next = 1'b1;
                        phase_next   = PH_HDR0;
                    end
                    else if (rx_byte[6:0] == LEN_EXT64)
                    begin
                        req_valid    = 1'b1;
                        req.status   = ST_LONG_LENGTH;
                        discard_next = 1'b1;
                        phase_next   = PH_HDR0;
                    end
                    else if (rx_byte[6:0] == LEN_EXT16)
                    begin
                        if (start_reg < 11'd8)
                        begin
                            req_valid    = 1'b1;
                            req.status   = ST_SHORT_HDR;
                            discard_next = 1'b1;
                            phase_next   = PH_HDR0;
                        end
                        else
                            phase_next = PH_EXT_HI;
                    end
                    else
                    begin
                        length_next = {9'd0, rx_byte[6:0]};
                        fit_need    = HDR_SHORT + {10'd0, rx_byte[6:0]};
                        if (17'(start_reg) < fit_need)
                        begin
                            req_valid    = 1'b1;
                            req.status   = ST_SHORT_FRAME;
                            discard_next = 1'b1;
                            phase_next   = PH_HDR0;
                        end
                        else
                        begin
                            drop_next     = (opcode_reg != OP_BINARY);
                            position_next = '0;
                            phase_next    = PH_MASK0;
                        end
                    end
                end
                PH_EXT_HI:
                begin
                    length_next = {rx_byte, 8'd0};
                    phase_next  = PH_EXT_LO;
                end
                PH_EXT_LO:
                begin
                    length_next = {length_reg[15:8], rx_byte};
                    fit_need    = HDR_EXT16 + {1'b0, length_reg[15:8], rx_byte};
                    if (17'(start_reg) < fit_need)
                    begin
                        req_valid    = 1'b1;
                        req.status   = ST_SHORT_FRAME;
                        discard_next = 1'b1;
                        phase_next   = PH_HDR0;
                    end
                    else
                    begin
                        drop_next     = (opcode_reg != OP_BINARY);
                        position_next = '0;
                        phase_next    = PH_MASK0;
                    end
                end
                PH_MASK0, PH_MASK1, PH_MASK2:
                begin
                    mask_next  = {mask_reg[23:0], rx_byte};
                    phase_next = phase_t'(phase_reg + 4'd1);
                end
                PH_MASK3:
                begin
                    mask_next = {mask_reg[23:0], rx_byte};
                    if (length_reg == 16'd0)
                    begin
                        phase_next = PH_HDR0;
                        if (!drop_reg)
                        begin
                            req_valid    = 1'b1;
                            req.status   = ST_EMPTY_MSG;
                            discard_next = 1'b1;
                        end
                    end
                    else
                        phase_next = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    if (!drop_reg)
                    begin
                        req_valid     = 1'b1;
                        req.data      = rx_byte;
                        req.frame_end = pay_end;
                        req.status    = ST_DATA;
                        case (key_sel)
                            2'd0:    req.key = mask_reg[31:24];
                            2'd1:    req.key = mask_reg[23:16];
                            2'd2:    req.key = mask_reg[15:8];
                            default: req.key = mask_reg[7:0];
                        endcase
                    end
                    position_next = position_reg + 16'd1;
                    if (pay_end)
                        phase_next = PH_HDR0;
                end
                default:
                    phase_next = PH_HDR0;
            endcase
        end

        // end of receive buffer
        if (bl <= 11'd1)
        begin
            phase_next   = PH_HDR0;
            discard_next = 1'b0;
        end
    end

endmodule

`default_nettype wire

[rtl/wsd_fifo.sv]
// ----------------------------------------------------------------------------
// wsd_fifo
// Short request queue between the parser and the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsd_fifo
    import wsd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     wr_en,
    input  wire res_req_t wr_req,
    input  wire logic     rd_en,
    output res_req_t      rd_req,
    output logic          full,
    output logic          nonempty
);

    res_req_t             slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg, count_next;

    assign full     = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign nonempty = (count_reg != '0);
    assign rd_req   = slot_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (!wr_en && rd_en)
            count_next = count_reg - 1'b1;
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_req;
    end

endmodule

`default_nettype wire

[rtl/wsd_back.sv]
// ----------------------------------------------------------------------------
// wsd_back
// Output stage: unmasks queued requests into a result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsd_back
    import wsd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_avail,
    input  wire res_req_t req,
    output logic          req_take,
    input  wire logic     pop,
    output logic          empty,
    output logic [7:0]    payload_byte,
    output logic          frame_end,
    output logic [2:0]    status
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       end_reg;
    logic [2:0] status_reg;

    // refill when the result slot is free or being taken
    assign req_take = req_avail && (!valid_reg || pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (req_take)
            valid_reg <= 1'b1;
        else if (pop)
            valid_reg <= 1'b0;
    end

    // unmask into the result register
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            byte_reg   <= req.data ^ req.key;
            end_reg    <= req.frame_end;
            status_reg <= req.status;
        end
    end

    assign empty        = !valid_reg;
    assign payload_byte = byte_reg;
    assign frame_end    = end_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire

[rtl/websocket_frame_deframer_unmasker.sv]
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unmasker
// Parses client websocket frames byte by byte and delivers unmasked binary
// payload bytes or one error status per receive buffer.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: drive rx_byte and bytes_left with push;
//   a byte is taken on a clock edge where push is high and full is low.
//   Result side is a queue read port: while empty is low the oldest result is
//   on payload_byte, frame_end and status; pop high takes it.
//   Throughput: one byte per cycle while full is low, set by the header parser.
//   The parser writes a result request into the queue as its byte is taken,
//   and the output stage then registers the unmasked byte for the reader.
//   Header, length and mask bytes produce no result unless they raise an error.
//   When the reader stalls, the 4-entry request queue and the result register
//   absorb results; full rises once the queue is full, and bytes are never
//   lost.
//   Reset (rst_n low, asynchronous) returns the parser to the first header
//   byte and empties the queue and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer_unmasker
    import wsd_pkg::*;
#(
    parameter int BUFFER_BYTES = 1024
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [10:0] bytes_left,
    input  wire logic        pop,
    output logic             empty,
    output logic [7:0]       payload_byte,
    output logic             frame_end,
    output logic [2:0]       status
);

    logic     in_valid;
    logic     req_valid;
    res_req_t req;
    res_req_t q_req;
    logic     q_nonempty;
    logic     q_take;

    assign in_valid = push && !full;

    // header parser
    wsd_front #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .rx_byte    (rx_byte),
        .bytes_left (bytes_left),
        .req_valid  (req_valid),
        .req        (req)
    );

    // request queue
    wsd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (in_valid && req_valid),
        .wr_req   (req),
        .rd_en    (q_take),
        .rd_req   (q_req),
        .full     (full),
        .nonempty (q_nonempty)
    );

    // unmask and output register
    wsd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_avail    (q_nonempty),
        .req          (q_req),
        .req_take     (q_take),
        .pop          (pop),
        .empty        (empty),
        .payload_byte (payload_byte),
        .frame_end    (frame_end),
        .status       (status)
    );

endmodule

`default_nettype wire

[verif/tb_websocket_frame_deframer_unmasker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer_unmasker
// Streams receive buffers of client websocket frames into the deframer, one
// byte per request, and predicts every unmasked payload byte and error status
// with an in-bench parser model. Directed cases come first, then random
// buffers of mostly well-formed frames under three sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer_unmasker;
    import wsd_pkg::*;

    localparam int BUF_BYTES   = 1024;
    localparam int MAX_TAG     = 2047;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_SLACK = 10;

    // how the payload length is encoded in a generated frame
    typedef enum int {
        LF_7BIT,
        LF_16BIT,
        LF_64BIT
    } len_form_t;

    // one result as seen on the output ports
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [2:0] code;
    } deframed_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic [7:0]  rx_byte = 8'd0;
    logic [10:0] bytes_left = 11'd0;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic [7:0]  payload_byte;
    logic        frame_end;
    logic [2:0]  status;

    // predicted parser state
    phase_t      prs_phase = PH_HDR0;
    logic [3:0]  frm_opcode = 4'd0;
    logic [15:0] frm_len = 16'd0;
    logic [15:0] frm_pos = 16'd0;
    logic [31:0] mask_word = 32'd0;
    logic [10:0] start_room = 11'd0;
    logic        frm_drop = 1'b0;
    logic        skip_rest = 1'b0;

    deframed_t   expected_out[$];
    logic [7:0]  buf_bytes[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int bytes_sent = 0;
    int results_seen = 0;
    int err_count = 0;
    int stall_cycles = 0;

    websocket_frame_deframer_unmasker #(
        .BUFFER_BYTES (BUF_BYTES)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .rx_byte      (rx_byte),
        .bytes_left   (bytes_left),
        .pop          (pop),
        .empty        (empty),
        .payload_byte (payload_byte),
        .frame_end    (frame_end),
        .status       (status)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // parser prediction
    // ------------------------------------------------------------------------

    // error: one status result, then ignore the rest of the buffer
    function automatic void reject_buffer(input logic [2:0] code);
        skip_rest = 1'b1;
        prs_phase = PH_HDR0;
        expected_out.push_back({8'd0, 1'b0, code});
    endfunction

    // whole frame must fit into what was left at its first byte
    function automatic void fit_check(input logic [16:0] hdr);
        if (17'(start_room) < hdr + 17'(frm_len))
            reject_buffer(ST_SHORT_FRAME);
        else
        begin
            frm_drop = (frm_opcode != OP_BINARY);
            frm_pos = 16'd0;
            prs_phase = PH_MASK0;
        end
    endfunction

    function automatic void deframe_predict(input logic [7:0] b, input logic [10:0] tag);
        logic [10:0] room;
        logic [7:0]  key_b;
        logic        last;
        room = (tag > 11'(BUF_BYTES)) ? 11'(BUF_BYTES) : tag;
        if (!skip_rest)
        begin
            case (prs_phase)
                PH_HDR0:
                begin
                    start_room = room;
                    if (17'(room) < HDR_SHORT)
                        reject_buffer(ST_SHORT_HDR);
                    else if (!b[7])
                        reject_buffer(ST_NOT_FINAL);
                    else
                    begin
                        frm_opcode = b[3:0];
                        prs_phase = PH_HDR1;
                    end
                end
                PH_HDR1:
                begin
                    if (!b[7])
                        reject_buffer(ST_UNMASKED);
                    else if (b[6:0] == LEN_EXT64)
                        reject_buffer(ST_LONG_LENGTH);
                    else if (b[6:0] == LEN_EXT16)
                    begin
                        if (17'(start_room) < HDR_EXT16)
                            reject_buffer(ST_SHORT_HDR);
                        else
                            prs_phase = PH_EXT_HI;
                    end
                    else
                    begin
                        frm_len = {9'd0, b[6:0]};
                        fit_check(HDR_SHORT);
                    end
                end
                PH_EXT_HI:
                begin
                    frm_len = {b, 8'd0};
                    prs_phase = PH_EXT_LO;
                end
                PH_EXT_LO:
                begin
                    frm_len[7:0] = b;
                    fit_check(HDR_EXT16);
                end
                PH_MASK0, PH_MASK1, PH_MASK2, PH_MASK3:
                begin
                    mask_word = {mask_word[23:0], b};
                    if (prs_phase == PH_MASK3)
                    begin
                        // empty binary message is an error, other empties vanish
                        if (frm_len == 16'd0)
                        begin
                            if (!frm_drop)
                                reject_buffer(ST_EMPTY_MSG);
                            else
                                prs_phase = PH_HDR0;
                        end
                        else
                            prs_phase = PH_PAYLOAD;
                    end
                    else
                        prs_phase = phase_t'(prs_phase + 1);
                end
                PH_PAYLOAD:
                begin
                    key_b = mask_word[8 * (3 - int'(frm_pos[1:0])) +: 8];
                    last = ((17'(frm_pos) + 17'd1) == 17'(frm_len));
                    if (!frm_drop)
                        expected_out.push_back({b ^ key_b, last, ST_DATA});
                    frm_pos = frm_pos + 16'd1;
                    if (last)
                        prs_phase = PH_HDR0;
                end
                default:
                    prs_phase = PH_HDR0;
            endcase
        end
        // last byte of a buffer restarts the parser
        if (room <= 11'd1)
        begin
            prs_phase = PH_HDR0;
            skip_rest = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    task automatic send_byte(input logic [7:0] b, input logic [10:0] tag);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push = 1'b1;
        rx_byte = b;
        bytes_left = tag;
        do
            @(posedge clk);
        while (full);
        deframe_predict(b, tag);
        bytes_sent++;
    endtask

    // tags count down from first_tag; the last byte carries 1 or 0
    task automatic send_buffer(input int first_tag, input logic zero_end);
        int tag;
        foreach (buf_bytes[i])
        begin
            if (i == buf_bytes.size() - 1)
                tag = zero_end ? 0 : 1;
            else
                tag = (first_tag - i < 2) ? 2 : first_tag - i;
            if (tag > MAX_TAG)
                tag = MAX_TAG;
            send_byte(buf_bytes[i], 11'(tag));
        end
        buf_bytes.delete();
    endtask

    // append one frame with random key, reserved bits and payload
    task automatic add_frame(input logic fin, input logic masked, input logic [3:0] opcode,
                             input int len, input len_form_t form);
        logic [31:0] key;
        key = $urandom;
        buf_bytes.push_back({fin, 3'($urandom_range(7)), opcode});
        case (form)
            LF_7BIT:
                buf_bytes.push_back({masked, 7'(len)});
            LF_16BIT:
            begin
                buf_bytes.push_back({masked, LEN_EXT16});
                buf_bytes.push_back(8'(len >> 8));
                buf_bytes.push_back(8'(len));
            end
            default:
            begin
                buf_bytes.push_back({masked, LEN_EXT64});
                repeat (6) buf_bytes.push_back(8'd0);
                buf_bytes.push_back(8'(len >> 8));
                buf_bytes.push_back(8'(len));
            end
        endcase
        for (int k = 3; k >= 0; k--)
            buf_bytes.push_back(key[8 * k +: 8]);
        repeat (len) buf_bytes.push_back(8'($urandom));
    endtask

    // stop sending until every predicted result has come out
    task automatic drain_results();
        @(negedge clk);
        push = 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    // random pop pattern
    always @(negedge clk)
    begin
        pop = ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each popped result with the oldest prediction
    always @(posedge clk)
    begin
        deframed_t want;
        if (rst_n && pop && !empty)
        begin
            results_seen++;
            if (expected_out.size() == 0)
            begin
                $error("unexpected result: payload_byte %0h frame_end %0b status %0d",
                       payload_byte, frame_end, status);
                err_count++;
            end
            else
            begin
                want = expected_out.pop_front();
                if (payload_byte !== want.data)
                begin
                    $error("payload_byte mismatch: expected %0h, actual %0h",
                           want.data, payload_byte);
                    err_count++;
                end
                if (frame_end !== want.last)
                begin
                    $error("frame_end mismatch: expected %0b, actual %0b",
                           want.last, frame_end);
                    err_count++;
                end
                if (status !== want.code)
                begin
                    $error("status mismatch: expected %0d, actual %0d", want.code, status);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles with no request moving either way
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no request accepted for %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // binary frames, payload and mask extremes, 16-bit length, clamped tag
    task automatic test_binary_frames();
        buf_bytes = '{8'h82, 8'h81, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                      8'h82, 8'h82, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
        send_buffer(15, 1'b0);
        // short length sent in extended form, tag far above buffer size
        buf_bytes = '{8'hF2, 8'hFE, 8'h00, 8'h05, 8'hA5, 8'h5A, 8'h3C, 8'hC3,
                      8'h12, 8'h34, 8'h56, 8'h78, 8'h9A};
        send_buffer(MAX_TAG, 1'b0);
    endtask

    // every header error, short header in both length forms; bytes after the error are discarded
    task automatic test_header_errors();
        buf_bytes = '{8'h02, 8'h82};
        send_buffer(6, 1'b0);
        buf_bytes = '{8'h82, 8'h05, 8'h00};
        send_buffer(6, 1'b0);
        buf_bytes = '{8'h82, 8'hFF, 8'h00};
        send_buffer(9, 1'b0);
        // fewer than six bytes left, buffer closed by a zero tag
        buf_bytes = '{8'h82, 8'h00};
        send_buffer(5, 1'b1);
        // extended length with room for a short header only
        buf_bytes = '{8'h82, 8'hFE, 8'h00};
        send_buffer(7, 1'b0);
        // frame longer than the buffer
        buf_bytes = '{8'h82, 8'h85, 8'h00};
        send_buffer(10, 1'b0);
    endtask

    // empty text frame vanishes, empty binary frame is an error
    task automatic test_empty_frames();
        buf_bytes = '{8'h81, 8'h80, 8'h11, 8'h22, 8'h33, 8'h44,
                      8'h82, 8'h80, 8'h55, 8'h66, 8'h77, 8'h88};
        send_buffer(12, 1'b0);
    endtask

    // non-binary payload dropped, next binary frame still delivered
    task automatic test_dropped_opcodes();
        buf_bytes = '{8'h89, 8'h81, 8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'h42,
                      8'h82, 8'h81, 8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'h42};
        send_buffer(14, 1'b0);
    endtask

    // frame cut off by the end of its buffer, then a clean buffer
    task automatic test_buffer_end();
        buf_bytes = '{8'h82, 8'h83, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20};
        send_buffer(9, 1'b0);
        buf_bytes = '{8'h82, 8'h81, 8'h80, 8'h40, 8'h20, 8'h10, 8'h7F};
        send_buffer(7, 1'b1);
    endtask

    // random buffers: mostly well-formed frames, some broken, some noise
    task automatic test_random_traffic(input int n_bytes);
        int        stop_at;
        int        nfr;
        int        err;
        int        lroll;
        int        len;
        int        total;
        int        shape;
        int        first_tag;
        len_form_t form;
        logic [3:0] opcode;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            nfr = $urandom_range(1, 3);
            for (int f = 0; f < nfr; f++)
            begin
                err = $urandom_range(99);
                opcode = ($urandom_range(99) < 70) ? OP_BINARY : 4'($urandom_range(15));
                lroll = $urandom_range(99);
                if (lroll < 60)
                begin
                    len = $urandom_range(10);
                    form = LF_7BIT;
                end
                else if (lroll < 88)
                begin
                    len = $urandom_range(11, 125);
                    form = LF_7BIT;
                end
                else if (lroll < 97)
                begin
                    len = $urandom_range(200);
                    form = LF_16BIT;
                end
                else
                begin
                    len = $urandom_range(126, 300);
                    form = LF_16BIT;
                end
                if (err >= 6 && err < 9)
                    form = LF_64BIT;
                add_frame(err >= 3, err < 3 || err >= 6, opcode, len, form);
            end
            total = buf_bytes.size();
            shape = $urandom_range(99);
            first_tag = total + $urandom_range(2);
            if (shape < 10)
                first_tag = total - $urandom_range(1, 6);
            else if (shape < 20)
                repeat ($urandom_range(1, total - 1)) buf_bytes.pop_back();
            else if (shape < 25)
                first_tag = $urandom_range(total, MAX_TAG);
            else if (shape < 30)
            begin
                buf_bytes.delete();
                repeat ($urandom_range(1, 12)) buf_bytes.push_back(8'($urandom));
                first_tag = $urandom_range(MAX_TAG);
            end
            send_buffer(first_tag, $urandom_range(9) == 0);
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // sender idles lightly, receiver stalls half the time
        send_idle_pct = 13;
        recv_idle_pct = 51;
        test_binary_frames();
        test_header_errors();
        test_empty_frames();
        test_dropped_opcodes();
        test_buffer_end();
        drain_results();
        test_random_traffic(60);
        drain_results();

        // the other way round
        send_idle_pct = 51;
        recv_idle_pct = 13;
        test_random_traffic(70);
        drain_results();

        // full rate both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(70);
        drain_results();

        $display("sent %0d bytes in directed and random buffers, checked %0d results",
                 bytes_sent, results_seen);
        $display("covered payload unmasking, dropped opcodes and every header error");
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
rtl/wsd_pkg.sv
rtl/wsd_front.sv
rtl/wsd_fifo.sv
rtl/wsd_back.sv
rtl/websocket_frame_deframer_unmasker.sv
verif/tb_websocket_frame_deframer_unmasker.sv
